>>> rtl/core/ffba_pkg.sv
package ffba_pkg;

	// default build sizes
	localparam int MAX_CELLS_DEF = 256;
	localparam int ID_BITS_DEF   = 16;

	// fixed field widths
	localparam int OPC_W    = 2;
	localparam int SIZE_W   = 9;
	localparam int EID_W    = 16;
	localparam int STAT_W   = 2;
	localparam int OUT_ID_W = 16;
	localparam int CELLS_W  = 9;

	localparam logic [CELLS_W-1:0] CELLS_RESET = 9'd256;

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic REG_CELLS_IN_USE = 1'b0;

	// operations
	localparam logic [OPC_W-1:0] OP_ALLOC      = 2'd0;
	localparam logic [OPC_W-1:0] OP_ERASE      = 2'd1;
	localparam logic [OPC_W-1:0] OP_DEFRAGMENT = 2'd2;

	// result codes
	localparam logic [STAT_W-1:0] ST_ALLOCATED              = 2'd0;
	localparam logic [STAT_W-1:0] ST_NULL                   = 2'd1;
	localparam logic [STAT_W-1:0] ST_ILLEGAL_ERASE_ARGUMENT = 2'd2;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic [OUT_ID_W-1:0] block_id;
	} res_t;

endpackage

>>> rtl/core/first_fit_block_allocator_core.sv
// alloc scans the active cells and stamps the first run that fits; erase answers only
// when the id is absent, defragment never; zero size, spent ids, erase of 0 skip the scan
// throughput: one request at a time, bounded by the single-cell read and write ports
// of the cell store; the next request is taken while a result waits at the output
// reset: asynchronous, active low; a clearing pass over all MAX_CELLS cells zeroes the
// store, during which no request is taken (configuration writes still land)
module first_fit_block_allocator_core #(
	parameter int MAX_CELLS = ffba_pkg::MAX_CELLS_DEF,
	parameter int ID_BITS   = ffba_pkg::ID_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ffba_pkg::OPC_W-1:0]         opcode,
	input  logic [ffba_pkg::SIZE_W-1:0]        request_size,
	input  logic [ffba_pkg::EID_W-1:0]         erase_id,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [ffba_pkg::STAT_W-1:0]        status,
	output logic [ffba_pkg::OUT_ID_W-1:0]      block_id,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ffba_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [ffba_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ffba_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);
	import ffba_pkg::*;

	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	logic [CELLS_W-1:0]  cells_q;
	logic                out_valid_q;
	res_t                out_q;

	logic                busy;
	logic                res_vld;
	res_t                res;
	logic                res_take;
	logic                out_free;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [ID_BITS-1:0]  rd_data;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [ID_BITS-1:0]  wr_data;

	// configuration register, word address picks the register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= CELLS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CELLS_IN_USE) begin
			cells_q <= pwdata[CELLS_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CELLS_IN_USE) ? APB_DATA_W'(cells_q) : '0;

	// one request in flight; the controller is free again once its result
	// has moved into the output register, or once a request with no answer ends
	assign in_stall = busy;

	// output register parts the controller from the downstream stall
	assign out_free = !out_valid_q || !out_stall;
	assign res_take = res_vld && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign block_id  = out_q.block_id;

	// sequencer: scans, stamps, frees and compacts the cell store
	ffba_ctrl #(
		.MAX_CELLS (MAX_CELLS),
		.ID_BITS   (ID_BITS),
		.AW        (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_valid && !in_stall),
		.opcode       (opcode),
		.request_size (request_size),
		.erase_id     (erase_id),
		.cells_in_use (cells_q),
		.busy         (busy),
		.res_vld      (res_vld),
		.res          (res),
		.res_take     (res_take),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

	// cell owner store, one read and one write port
	ffba_cell_mem #(
		.MAX_CELLS (MAX_CELLS),
		.ID_BITS   (ID_BITS),
		.AW        (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

>>> rtl/core/ffba_cell_mem.sv
module ffba_cell_mem #(
	parameter int MAX_CELLS = ffba_pkg::MAX_CELLS_DEF,
	parameter int ID_BITS   = ffba_pkg::ID_BITS_DEF,
	parameter int AW        = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [ID_BITS-1:0] rd_data,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [ID_BITS-1:0] wr_data
);
	import ffba_pkg::*;

	logic [ID_BITS-1:0] mem [MAX_CELLS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/ffba_ctrl.sv
module ffba_ctrl #(
	parameter int MAX_CELLS = ffba_pkg::MAX_CELLS_DEF,
	parameter int ID_BITS   = ffba_pkg::ID_BITS_DEF,
	parameter int AW        = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [ffba_pkg::OPC_W-1:0]      opcode,
	input  logic [ffba_pkg::SIZE_W-1:0]     request_size,
	input  logic [ffba_pkg::EID_W-1:0]      erase_id,
	input  logic [ffba_pkg::CELLS_W-1:0]    cells_in_use,
	output logic                            busy,
	output logic                            res_vld,
	output ffba_pkg::res_t                  res,
	input  logic                            res_take,
	output logic                            rd_en,
	output logic [AW-1:0]                   rd_addr,
	input  logic [ID_BITS-1:0]              rd_data,
	output logic                            wr_en,
	output logic [AW-1:0]                   wr_addr,
	output logic [ID_BITS-1:0]              wr_data
);
	import ffba_pkg::*;

	localparam int CW    = $clog2(MAX_CELLS + 1);
	localparam int EW    = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
	localparam int CMP_W = (ID_BITS > EID_W) ? ID_BITS : EID_W;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ASCAN = 3'd2;
	localparam logic [2:0] S_AFILL = 3'd3;
	localparam logic [2:0] S_ESCAN = 3'd4;
	localparam logic [2:0] S_DSCAN = 3'd5;
	localparam logic [2:0] S_DTAIL = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]          state_q;
	logic [ID_BITS-1:0]  next_id_q;
	logic [CW-1:0]       rd_q;
	logic                vld_s1;
	logic [AW-1:0]       idx_s1;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       run_q;
	logic [CW-1:0]       w_q;
	logic [SIZE_W-1:0]   size_q;
	logic [EID_W-1:0]    erase_q;
	logic [AW-1:0]       fill_q;
	logic [AW-1:0]       last_q;
	logic                found_q;
	res_t                res_q;

	logic [CW-1:0]       active_n;
	logic [CW-1:0]       run_nxt;
	logic                scanning;
	logic                scan_end;
	logic                cell_used;
	logic                id_match;
	logic                run_done;
	logic [AW-1:0]       fill_start;

	// cells beyond the built depth act as the built depth
	assign active_n = (EW'(cells_in_use) > EW'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(cells_in_use);

	assign scanning   = (state_q == S_ASCAN) || (state_q == S_ESCAN) || (state_q == S_DSCAN);
	assign scan_end   = !vld_s1 && (rd_q >= n_q);
	assign cell_used  = (rd_data != '0);
	assign id_match   = (CMP_W'(rd_data) == CMP_W'(erase_q));
	assign run_nxt    = run_q + CW'(1);
	assign run_done   = (EW'(run_nxt) == EW'(size_q));
	assign fill_start = AW'(EW'(idx_s1) + EW'(1) - EW'(size_q));

	assign busy    = (state_q != S_IDLE);
	assign res_vld = (state_q == S_DONE);
	assign res     = res_q;

	// read side: one cell a cycle while a scan is open
	assign rd_en   = scanning && (rd_q < n_q);
	assign rd_addr = rd_q[AW-1:0];

	// write side
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_q[AW-1:0];
		wr_data = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_AFILL: begin
				wr_en   = 1'b1;
				wr_addr = fill_q;
				wr_data = next_id_q;
			end
			S_ESCAN: begin
				wr_en   = vld_s1 && id_match;
				wr_addr = idx_s1;
			end
			S_DSCAN: begin
				wr_en   = vld_s1 && cell_used;
				wr_addr = w_q[AW-1:0];
				wr_data = rd_data;
			end
			S_DTAIL: begin
				wr_en   = (w_q < n_q);
				wr_addr = w_q[AW-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			next_id_q <= ID_BITS'(1);
			rd_q      <= '0;
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			if (rd_en) begin
				rd_q <= rd_q + CW'(1);
			end
			case (state_q)
				S_CLEAR: begin
					rd_q <= rd_q + CW'(1);
					if (rd_q == CW'(MAX_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					rd_q <= '0;
					if (start) begin
						case (opcode)
							OP_ALLOC: begin
								if (request_size == '0 || next_id_q == '0) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_ASCAN;
								end
							end
							OP_ERASE: begin
								if (erase_id == '0) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_ESCAN;
								end
							end
							OP_DEFRAGMENT: begin
								state_q <= S_DSCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ASCAN: begin
					if (vld_s1 && !cell_used && run_done) begin
						state_q <= S_AFILL;
					end else if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_AFILL: begin
					if (fill_q == last_q) begin
						next_id_q <= next_id_q + ID_BITS'(1);
						state_q   <= S_DONE;
					end
				end
				S_ESCAN: begin
					if (scan_end) begin
						state_q <= found_q ? S_IDLE : S_DONE;
					end
				end
				S_DSCAN: begin
					if (scan_end) begin
						state_q <= S_DTAIL;
					end
				end
				S_DTAIL: begin
					if (w_q >= n_q) begin
						state_q <= S_IDLE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		case (state_q)
			S_IDLE: begin
				n_q            <= active_n;
				size_q         <= request_size;
				erase_q        <= erase_id;
				run_q          <= '0;
				w_q            <= '0;
				found_q        <= 1'b0;
				res_q.status   <= (opcode == OP_ERASE) ? ST_ILLEGAL_ERASE_ARGUMENT : ST_NULL;
				res_q.block_id <= '0;
			end
			S_ASCAN: begin
				if (vld_s1) begin
					if (cell_used) begin
						run_q <= '0;
					end else begin
						run_q <= run_nxt;
					end
					fill_q <= fill_start;
					last_q <= idx_s1;
				end
			end
			S_AFILL: begin
				fill_q <= fill_q + AW'(1);
				if (fill_q == last_q) begin
					res_q <= '{status: ST_ALLOCATED, block_id: OUT_ID_W'(next_id_q)};
				end
			end
			S_ESCAN: begin
				if (vld_s1 && id_match) begin
					found_q <= 1'b1;
				end
			end
			S_DSCAN: begin
				if (vld_s1 && cell_used) begin
					w_q <= w_q + CW'(1);
				end
			end
			S_DTAIL: begin
				if (w_q < n_q) begin
					w_q <= w_q + CW'(1);
				end
			end
			default: begin
				found_q <= found_q;
			end
		endcase
	end

endmodule

>>> bench/ffba_checker.sv
module ffba_checker #(
	parameter int MAX_CELLS = ffba_pkg::MAX_CELLS_DEF,
	parameter int ID_BITS   = ffba_pkg::ID_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [ffba_pkg::OPC_W-1:0]      opcode,
	input  logic [ffba_pkg::SIZE_W-1:0]     request_size,
	input  logic [ffba_pkg::EID_W-1:0]      erase_id,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [ffba_pkg::STAT_W-1:0]     status,
	input  logic [ffba_pkg::OUT_ID_W-1:0]   block_id,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ffba_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ffba_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [ffba_pkg::APB_DATA_W-1:0] prdata,
	input  logic                            pready,
	output int                              fails,
	output int                              waiting,
	output logic [ID_BITS-1:0]              next_ident
);
	import ffba_pkg::*;

	localparam logic [APB_ADDR_W-1:0] CELLS_ADDR = APB_ADDR_W'({REG_CELLS_IN_USE, 2'b00});
	// answers outstanding never exceed two, the ring has ample room
	localparam int DUE_DEPTH = 16;

	logic [ID_BITS-1:0] owner [MAX_CELLS];
	logic [CELLS_W-1:0] row_len;
	res_t               due_buf [DUE_DEPTH];
	int                 due_wr;
	int                 due_rd;
	int                 due_cnt;

	function automatic int managed_cells();
		return (int'(row_len) > MAX_CELLS) ? MAX_CELLS : int'(row_len);
	endfunction

	// expected answer goes to the tail of the ring
	task automatic log_answer(input res_t r);
		due_buf[due_wr] = r;
		due_wr          = (due_wr + 1) % DUE_DEPTH;
		due_cnt++;
	endtask

	// first-fit alloc, erase, compaction on the shadow store
	task automatic serve_request(input logic [OPC_W-1:0] op, input logic [SIZE_W-1:0] size,
			input logic [EID_W-1:0] eid);
		int   n;
		int   run;
		int   w;
		bit   hit;
		res_t r;
		n   = managed_cells();
		r   = '0;
		hit = 1'b0;
		run = 0;
		case (op)
			OP_ALLOC: begin
				r.status = ST_NULL;
				if (size != '0 && next_ident != '0) begin
					for (int j = 0; j < n && !hit; j++) begin
						if (owner[j] != '0) begin
							run = 0;
						end else begin
							run++;
							if (run == int'(size)) begin
								for (int k = j + 1 - int'(size); k <= j; k++)
									owner[k] = next_ident;
								r.status   = ST_ALLOCATED;
								r.block_id = OUT_ID_W'(next_ident);
								next_ident = next_ident + ID_BITS'(1);
								hit        = 1'b1;
							end
						end
					end
				end
				log_answer(r);
			end
			OP_ERASE: begin
				if (eid != '0) begin
					for (int j = 0; j < n; j++) begin
						if (32'(owner[j]) == 32'(eid)) begin
							owner[j] = '0;
							hit      = 1'b1;
						end
					end
				end
				if (!hit) begin
					r.status = ST_ILLEGAL_ERASE_ARGUMENT;
					log_answer(r);
				end
			end
			OP_DEFRAGMENT: begin
				w = 0;
				for (int j = 0; j < n; j++) begin
					if (owner[j] != '0) begin
						owner[w] = owner[j];
						w++;
					end
				end
				for (int j = w; j < n; j++)
					owner[j] = '0;
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			for (int j = 0; j < MAX_CELLS; j++)
				owner[j] = '0;
			next_ident = ID_BITS'(1);
			row_len    = CELLS_RESET;
			due_wr     = 0;
			due_rd     = 0;
			due_cnt    = 0;
			fails      = 0;
		end else begin
			// register port
			if (psel && penable && pready && paddr == CELLS_ADDR) begin
				if (pwrite) begin
					row_len = pwdata[CELLS_W-1:0];
				end else if (prdata !== APB_DATA_W'(row_len)) begin
					$display("%0t cells_in_use read expected %0d got %0d", $time, row_len, prdata);
					fails++;
				end
			end
			// result channel, oldest expectation first
			if (out_valid && !out_stall) begin
				if (due_cnt == 0) begin
					$display("%0t unexpected result expected none got status %0d block_id %0d",
						$time, status, block_id);
					fails++;
				end else begin
					want   = due_buf[due_rd];
					due_rd = (due_rd + 1) % DUE_DEPTH;
					due_cnt--;
					if (status !== want.status) begin
						$display("%0t status expected %0d got %0d", $time, want.status, status);
						fails++;
					end
					if (block_id !== want.block_id) begin
						$display("%0t block_id expected %0d got %0d", $time, want.block_id,
							block_id);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall)
				serve_request(opcode, request_size, erase_id);
		end
		waiting = due_cnt;
	end

endmodule

>>> bench/tb.sv
module tb;
	import ffba_pkg::*;

	localparam int CELLS       = MAX_CELLS_DEF;
	localparam int IDW         = ID_BITS_DEF;
	localparam int PERIOD      = 8;
	// longest busy stretch is a full compaction, about two passes over the store
	localparam int DRAIN       = 2 * CELLS + 8;
	// the long receiver hold-off, well below the watchdog
	localparam int HOLD_CYCLES = 3000;
	// quiet cycles allowed: hold-off plus a compaction plus the clearing pass, with margin
	localparam int QUIET_LIMIT = 20000;
	localparam int PHASE_ITEMS = 100;

	// opcode with no operation behind it
	localparam logic [OPC_W-1:0]      OP_UNUSED  = 2'd3;
	localparam logic [APB_ADDR_W-1:0] CELLS_ADDR = APB_ADDR_W'({REG_CELLS_IN_USE, 2'b00});

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [OPC_W-1:0]      opcode;
	logic [SIZE_W-1:0]     request_size;
	logic [EID_W-1:0]      erase_id;
	logic                  out_valid;
	logic                  out_stall;
	logic [STAT_W-1:0]     status;
	logic [OUT_ID_W-1:0]   block_id;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int                    fails;
	int                    waiting;
	logic [IDW-1:0]        next_ident;

	// receiver control: one long hold-off on demand
	bit                    pressure_on;

	// row sizes of the random phases, small and large, extremes included
	int                    row_plan [10] = '{24, 256, 1, 8, 64, 300, 3, 128, 12, 511};

	first_fit_block_allocator_core #(
		.MAX_CELLS(CELLS),
		.ID_BITS  (IDW)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.request_size(request_size),
		.erase_id    (erase_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.block_id    (block_id),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	ffba_checker #(
		.MAX_CELLS(CELLS),
		.ID_BITS  (IDW)
	) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.request_size(request_size),
		.erase_id    (erase_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.block_id    (block_id),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.fails       (fails),
		.waiting     (waiting),
		.next_ident  (next_ident)
	);

	always #(PERIOD / 2) clk = ~clk;

	// drop valid for a gap of n, a gap of zero leaves it up
	task automatic idle_for(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// offer one request from a falling edge, hold it until taken
	task automatic send(input logic [OPC_W-1:0] op, input logic [SIZE_W-1:0] size,
			input logic [EID_W-1:0] eid);
		in_valid     <= 1'b1;
		opcode       <= op;
		request_size <= size;
		erase_id     <= eid;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// one register access, setup then access phase
	task automatic apb_xfer(input bit wr, input logic [CELLS_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= CELLS_ADDR;
		pwdata  <= APB_DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// quiet the block: every answer back, then room for a request with no answer
	task automatic settle();
		in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// new row size only when idle, then read it back
	task automatic set_row(input logic [CELLS_W-1:0] val);
		settle();
		apb_xfer(1'b1, val);
		apb_xfer(1'b0, '0);
	endtask

	// random request: mostly allocs of modest size and erases of recent ids
	task automatic pick_request(input int row, output logic [OPC_W-1:0] op,
			output logic [SIZE_W-1:0] size, output logic [EID_W-1:0] eid);
		int eff;
		int quarter;
		int sel;
		int sub;
		eff     = (row > CELLS) ? CELLS : row;
		if (eff < 1)
			eff = 1;
		quarter = (eff / 4 < 1) ? 1 : eff / 4;
		sel     = $urandom_range(0, 99);
		sub     = $urandom_range(0, 99);
		size    = SIZE_W'($urandom);
		eid     = EID_W'($urandom);
		if (sel < 45) begin
			op = OP_ALLOC;
			if (sub < 70)
				size = SIZE_W'($urandom_range(1, quarter));
			else if (sub < 85)
				size = SIZE_W'($urandom_range(1, eff));
			else if (sub < 90)
				size = '0;
			else if (sub < 95)
				size = SIZE_W'($urandom_range(eff, eff + 1));
			else
				size = SIZE_W'($urandom_range(0, 511));
		end else if (sel < 78) begin
			op = OP_ERASE;
			// recent ids are likely still live
			if (sub < 80)
				eid = EID_W'(next_ident - IDW'($urandom_range(1, 12)));
			else if (sub < 90)
				eid = '0;
		end else if (sel < 93) begin
			op = OP_DEFRAGMENT;
		end else begin
			op = OP_UNUSED;
		end
	endtask

	// receiver: stall patterns in segments, one long hold-off when asked
	initial begin : result_sink
		int seg;
		int mode;
		bit held;
		held      = 1'b0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (pressure_on && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				seg  = $urandom_range(1, 200);
				repeat (seg) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= ($urandom_range(0, 9) < 7);
						default: out_stall <= !out_stall;
					endcase
					@(negedge clk);
				end
			end
		end
	end

	// watchdog: too long without any request, result or register access
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [OPC_W-1:0]  op;
		logic [SIZE_W-1:0] sz;
		logic [EID_W-1:0]  eid;
		int                gap_cap;
		int                burst;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_ALLOC;
		request_size = '0;
		erase_id     = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pressure_on  = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset value of the row size, read during the clearing pass
		apb_xfer(1'b0, '0);

		// directed: full row of 256, ids handed out from 1
		send(OP_ALLOC, 9'd0, 16'hffff);          // zero size answers null
		send(OP_ALLOC, 9'd1, 16'h0000);          // id 1 in cell 0
		send(OP_ALLOC, 9'd256, 16'h0000);        // one cell short
		send(OP_ALLOC, 9'h1ff, 16'h0000);        // larger than the row
		send(OP_ALLOC, 9'd255, 16'h0000);        // id 2 fills the rest
		send(OP_ALLOC, 9'd1, 16'h0000);          // store full
		send(OP_ERASE, 9'h1ff, 16'h0000);        // erase of zero is illegal
		send(OP_ERASE, 9'd0, 16'hffff);          // absent id is illegal
		send(OP_ERASE, 9'd0, 16'd1);             // frees cell 0
		send(OP_DEFRAGMENT, 9'h1ff, 16'hffff);   // id 2 slides to the front
		send(OP_ALLOC, 9'd1, 16'h0000);          // id 3 in the freed tail
		send(OP_UNUSED, 9'h1ff, 16'hffff);       // ignored, no answer
		send(OP_ERASE, 9'd0, 16'd2);
		send(OP_ERASE, 9'd0, 16'd2);             // already gone
		send(OP_ERASE, 9'd0, 16'd3);

		// no cells managed at all
		set_row(9'd0);
		send(OP_ALLOC, 9'd1, 16'h0000);
		send(OP_ERASE, 9'd0, 16'd3);
		send(OP_DEFRAGMENT, 9'd0, 16'h0000);

		// above the store depth acts as the whole store
		set_row(9'h1ff);
		send(OP_ALLOC, 9'd256, 16'h0000);        // id 4 takes everything
		send(OP_ERASE, 9'd0, 16'd4);

		// cells past the row keep their owner
		set_row(9'd256);
		send(OP_ALLOC, 9'd3, 16'h0000);          // id 5 in cells 0..2
		set_row(9'd2);
		send(OP_ERASE, 9'd0, 16'd5);             // only cells 0 and 1 freed
		send(OP_DEFRAGMENT, 9'd0, 16'h0000);
		send(OP_ALLOC, 9'd1, 16'h0000);          // id 6 in cell 0
		send(OP_ALLOC, 9'd2, 16'h0000);          // one free cell only
		set_row(9'd256);
		send(OP_ERASE, 9'd0, 16'd5);             // cell 2 still held id 5
		send(OP_ERASE, 9'd0, 16'd6);

		// single cell row
		set_row(9'd1);
		send(OP_ALLOC, 9'd1, 16'h0000);
		send(OP_ALLOC, 9'd1, 16'h0000);
		send(OP_ERASE, 9'd0, 16'd7);

		// random phases, each on its own row size and pacing
		for (int ph = 0; ph < 10; ph++) begin
			set_row(CELLS_W'(row_plan[ph]));
			case ($urandom_range(0, 3))
				0: gap_cap = 0;
				1: gap_cap = 3;
				2: gap_cap = 12;
				default: gap_cap = 40;
			endcase
			// back pressure: receiver holds off while requests keep coming
			if (ph == 1) begin
				gap_cap     = 0;
				pressure_on = 1'b1;
			end
			burst = 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick_request(row_plan[ph], op, sz, eid);
				if (burst == 0) begin
					burst = $urandom_range(1, 16);
					idle_for($urandom_range(0, gap_cap));
				end
				burst--;
				send(op, sz, eid);
			end
		end

		// a last mix of requests on the final row
		send(OP_ALLOC, 9'd1, 16'h0000);
		send(OP_ALLOC, 9'd1, 16'h0000);
		send(OP_ALLOC, 9'd0, 16'h0000);
		send(OP_ERASE, 9'd0, 16'hffff);
		send(OP_DEFRAGMENT, 9'd0, 16'h0000);

		// drain and give the verdict
		settle();
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/core/ffba_pkg.sv
rtl/core/ffba_cell_mem.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator_core.sv
bench/ffba_checker.sv
bench/tb.sv
